// File: rtl/core/swlr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package swlr_pkg;

  localparam int FRAC_BITS = 13;
  localparam int MAX_WIDTH = 63;
  localparam logic [23:0] MARKER_COLOR = 24'h909030;
  localparam int MARKER_MIN = 5;

  localparam int CRD_W  = 18;
  localparam int PROD_W = 2 * CRD_W;
  localparam int ACC_W  = 32;
  localparam int COL_W  = ACC_W - FRAC_BITS + 1;
  localparam int SPAN_W = 8;
  localparam int ROWS_W = 17;
  localparam int CNT_W  = $clog2(PROD_W + 1);

  typedef enum logic [1:0] {
    REG_CLIP_W,
    REG_CLIP_H,
    REG_ORG_X,
    REG_ORG_Y
  } reg_e;

  typedef struct packed {
    logic              opcode;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] end_x;
    logic signed [15:0] end_y;
    logic [23:0]        start_color;
    logic [23:0]        end_color;
    logic [5:0]         line_width;
  } in_item_t;

  typedef struct packed {
    logic [12:0]        clip_width;
    logic [12:0]        clip_height;
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
  } cfg_t;

  typedef enum logic [1:0] {
    CMD_ADV,
    CMD_SETUP,
    CMD_KILL
  } cmd_e;

  typedef struct packed {
    logic                     x_major;
    logic                     row_dir;
    logic [ACC_W-1:0]         x_acc;
    logic [ACC_W-1:0]         x_step;
    logic [15:0]              row_y;
    logic [ROWS_W-1:0]        rows_left;
    logic signed [SPAN_W-1:0] span_lo;
    logic signed [SPAN_W-1:0] span_hi;
    logic [2:0][ACC_W-1:0]    c_acc;
    logic [2:0][ACC_W-1:0]    c_step;
  } line_t;

  typedef struct packed {
    cmd_e  kind;
    line_t line;
  } cmd_t;

  typedef struct packed {
    logic        pixel_valid;
    logic [15:0] pixel_x;
    logic [15:0] pixel_y;
    logic [23:0] pixel_color;
    logic        last_pixel;
  } res_t;

  typedef enum logic [3:0] {
    F_IDLE,
    F_XCLIP,
    F_XR,
    F_YT,
    F_YB,
    F_FIN,
    F_MUL,
    F_DIVGO,
    F_DIVW,
    F_APPLY,
    F_SEND,
    F_KILL
  } front_e;

  typedef enum logic [3:0] {
    J_XL_Y,
    J_XL_C,
    J_XR_Y,
    J_XR_C,
    J_YT_X,
    J_YT_C,
    J_YB_X,
    J_YB_C,
    J_XS,
    J_CS
  } job_e;

  typedef enum logic [1:0] {
    W_IDLE,
    W_SKIP,
    W_PUSH
  } walk_e;

  function automatic logic signed [COL_W-1:0] col_floor(input logic [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] s;
    s = $signed(a);
    return COL_W'(s >>> FRAC_BITS);
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/swlr_div.sv
`timescale 1ns / 1ps
`default_nettype none

module swlr_div import swlr_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic signed [PROD_W-1:0] num_i,
  input  wire logic signed [CRD_W-1:0]  den_i,
  output logic                          done_o,
  output logic signed [PROD_W-1:0]      quot_o
);

  logic               busy_q, busy_d, done_q, done_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [CRD_W-1:0]   rem_q, rem_d;
  logic [PROD_W-1:0]  quo_q, quo_d;
  logic [CRD_W-1:0]   dmag_q, dmag_d;
  logic               neg_q, neg_d, dz_q, dz_d;
  logic [CRD_W:0]     rsh;
  logic [CRD_W:0]     rsub;

  assign rsh  = {rem_q, quo_q[PROD_W-1]};
  assign rsub = rsh - {1'b0, dmag_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dmag_d = dmag_q;
    neg_d  = neg_q;
    dz_d   = dz_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(PROD_W);
      rem_d  = '0;
      quo_d  = num_i[PROD_W-1] ? PROD_W'(-num_i) : PROD_W'(num_i);
      dmag_d = den_i[CRD_W-1] ? CRD_W'(-den_i) : CRD_W'(den_i);
      neg_d  = num_i[PROD_W-1] ^ den_i[CRD_W-1];
      dz_d   = (den_i == '0);
    end else if (busy_q) begin
      if (rsh >= {1'b0, dmag_q}) begin
        rem_d = rsub[CRD_W-1:0];
        quo_d = {quo_q[PROD_W-2:0], 1'b1};
      end else begin
        rem_d = rsh[CRD_W-1:0];
        quo_d = {quo_q[PROD_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    dmag_q <= dmag_d;
    neg_q  <= neg_d;
    dz_q   <= dz_d;
  end

  assign done_o = done_q;
  assign quot_o = dz_q ? '0 : (neg_q ? -$signed(quo_q) : $signed(quo_q));

endmodule

`default_nettype wire

// File: rtl/core/swlr_setup.sv
`timescale 1ns / 1ps
`default_nettype none

module swlr_setup import swlr_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire cfg_t     cfg_i,
  input  wire logic     push_i,
  input  wire in_item_t item_i,
  output logic          full_o,
  output logic          cmd_valid_o,
  output cmd_t          cmd_o,
  input  wire logic     cmd_ready_i
);

  // input queue
  in_item_t   in_mem_q [2];
  logic       in_wr_q, in_rd_q;
  logic [1:0] in_cnt_q;
  logic       in_pop, in_push;
  in_item_t   head;

  assign full_o  = (in_cnt_q == 2'd2);
  assign in_push = push_i && !full_o;
  assign head    = in_mem_q[in_rd_q];

  always_ff @(posedge clk_i) begin
    if (in_push) in_mem_q[in_wr_q] <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_wr_q  <= 1'b0;
      in_rd_q  <= 1'b0;
      in_cnt_q <= '0;
    end else begin
      if (in_push) in_wr_q <= !in_wr_q;
      if (in_pop) in_rd_q <= !in_rd_q;
      in_cnt_q <= in_cnt_q + {1'b0, in_push} - {1'b0, in_pop};
    end
  end

  front_e                  state_q, state_d;
  job_e                    job_q, job_d;
  logic [1:0]              k_q, k_d;
  logic signed [CRD_W-1:0] x1_q, x1_d, y1_q, y1_d, x2_q, x2_d, y2_q, y2_d;
  logic [2:0][7:0]         c1_q, c1_d, c2_q, c2_d;
  logic [5:0]              lw_q, lw_d;
  logic                    xne_q, xne_d, yne_q, yne_d, dir_q, dir_d, xmaj_q, xmaj_d;
  logic signed [CRD_W-1:0] dy1_q, dy1_d, dx_q, dx_d, qd_q, qd_d;
  logic [ACC_W-1:0]        xstep_q, xstep_d;
  logic [2:0][ACC_W-1:0]   cstep_q, cstep_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [CRD_W-1:0]  den_q, den_d;

  logic                     div_start, div_done;
  logic signed [PROD_W-1:0] quot;
  logic signed [CRD_W-1:0]  qc;
  logic [7:0]               q8;

  logic signed [CRD_W-1:0] sxl, syl, one, op_a, op_b, op_d, c1e, c2e, dy;
  logic [5:0]              lw_sat;
  logic signed [SPAN_W-1:0] s_lo, s_hi;

  swlr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (prod_q),
    .den_i  (den_q),
    .done_o (div_done),
    .quot_o (quot)
  );

  assign qc  = quot[CRD_W-1:0];
  assign q8  = quot[7:0];
  assign sxl = $signed({{(CRD_W-13){1'b0}}, cfg_i.clip_width});
  assign syl = $signed({{(CRD_W-13){1'b0}}, cfg_i.clip_height});
  assign one = CRD_W'(1) <<< FRAC_BITS;
  assign c1e = $signed({{(CRD_W-8){1'b0}}, c1_q[k_q]});
  assign c2e = $signed({{(CRD_W-8){1'b0}}, c2_q[k_q]});
  assign dy  = y2_q - y1_q;

  always_comb begin
    op_a = '0;
    op_b = '0;
    op_d = x2_q - x1_q;
    unique case (job_q)
      J_XL_Y: begin op_a = x1_q;        op_b = y1_q - y2_q; end
      J_XL_C: begin op_a = c1e - c2e;   op_b = x1_q;        end
      J_XR_Y: begin op_a = y2_q - y1_q; op_b = x2_q - sxl;  end
      J_XR_C: begin op_a = x2_q - sxl;  op_b = c2e - c1e;   end
      J_YT_X: begin op_a = y1_q;        op_b = x1_q - x2_q; op_d = y2_q - y1_q; end
      J_YT_C: begin op_a = c1e - c2e;   op_b = y1_q;        op_d = y2_q - y1_q; end
      J_YB_X: begin op_a = x2_q - x1_q; op_b = y2_q - syl;  op_d = y2_q - y1_q; end
      J_YB_C: begin op_a = y2_q - syl;  op_b = c2e - c1e;   op_d = y2_q - y1_q; end
      J_XS:   begin op_a = dx_q;        op_b = one;         op_d = dy1_q; end
      J_CS:   begin op_a = c2e - c1e;   op_b = one;         op_d = qd_q;  end
      default: ;
    endcase
  end

  assign lw_sat = (lw_q > 6'(MAX_WIDTH)) ? 6'(MAX_WIDTH) : lw_q;
  assign s_lo   = (lw_sat > 6'd1) ? -$signed({2'b00, lw_sat[5:1]}) : '0;
  assign s_hi   = (lw_sat > 6'd1) ? s_lo + $signed({2'b00, lw_sat}) : SPAN_W'(1);

  always_comb begin
    cmd_o.kind           = CMD_SETUP;
    cmd_o.line.x_major   = xmaj_q;
    cmd_o.line.row_dir   = dir_q;
    cmd_o.line.x_acc     = ACC_W'(x1_q) << FRAC_BITS;
    cmd_o.line.x_step    = xstep_q;
    cmd_o.line.row_y     = y1_q[15:0];
    cmd_o.line.rows_left = ROWS_W'(dy1_q + CRD_W'(1));
    cmd_o.line.span_lo   = s_lo;
    cmd_o.line.span_hi   = s_hi;
    cmd_o.line.c_step    = cstep_q;
    for (int i = 0; i < 3; i++) cmd_o.line.c_acc[i] = ACC_W'(c1_q[i]) << FRAC_BITS;
    if (state_q == F_IDLE) cmd_o.kind = CMD_ADV;
    else if (state_q == F_KILL) cmd_o.kind = CMD_KILL;
  end

  always_comb begin
    state_d     = state_q;
    job_d       = job_q;
    k_d         = k_q;
    x1_d        = x1_q;
    y1_d        = y1_q;
    x2_d        = x2_q;
    y2_d        = y2_q;
    c1_d        = c1_q;
    c2_d        = c2_q;
    lw_d        = lw_q;
    xne_d       = xne_q;
    yne_d       = yne_q;
    dir_d       = dir_q;
    xmaj_d      = xmaj_q;
    dy1_d       = dy1_q;
    dx_d        = dx_q;
    qd_d        = qd_q;
    xstep_d     = xstep_q;
    cstep_d     = cstep_q;
    prod_d      = prod_q;
    den_d       = den_q;
    div_start   = 1'b0;
    in_pop      = 1'b0;
    cmd_valid_o = 1'b0;
    unique case (state_q)
      F_IDLE: begin
        if (in_cnt_q != 2'd0) begin
          if (head.opcode) begin
            cmd_valid_o = 1'b1;
            in_pop      = cmd_ready_i;
          end else begin
            in_pop = 1'b1;
            lw_d   = head.line_width;
            if (head.start_x > head.end_x) begin
              x1_d = CRD_W'(head.end_x);
              y1_d = CRD_W'(head.end_y);
              x2_d = CRD_W'(head.start_x);
              y2_d = CRD_W'(head.start_y);
              c1_d = head.end_color;
              c2_d = head.start_color;
            end else begin
              x1_d = CRD_W'(head.start_x);
              y1_d = CRD_W'(head.start_y);
              x2_d = CRD_W'(head.end_x);
              y2_d = CRD_W'(head.end_y);
              c1_d = head.start_color;
              c2_d = head.end_color;
            end
            state_d = F_XCLIP;
          end
        end
      end
      F_XCLIP: begin
        xne_d = (x2_q != x1_q);
        if (x2_q < 0 || x1_q >= sxl) begin
          state_d = F_KILL;
        end else if (x2_q != x1_q && x1_q < 0) begin
          job_d   = J_XL_Y;
          state_d = F_MUL;
        end else begin
          state_d = F_XR;
        end
      end
      F_XR: begin
        if (xne_q && x2_q >= sxl) begin
          job_d   = J_XR_Y;
          state_d = F_MUL;
        end else begin
          state_d = F_YT;
        end
      end
      F_YT: begin
        yne_d = (y2_q != y1_q);
        if (y2_q != y1_q && y1_q < 0) begin
          job_d   = J_YT_X;
          state_d = F_MUL;
        end else begin
          state_d = F_YB;
        end
      end
      F_YB: begin
        if (yne_q && y2_q >= syl) begin
          job_d   = J_YB_X;
          state_d = F_MUL;
        end else begin
          state_d = F_FIN;
        end
      end
      F_FIN: begin
        if (dy > 0) begin
          dir_d = 1'b0;
          dy1_d = dy + CRD_W'(1);
        end else begin
          dir_d = 1'b1;
          dy1_d = CRD_W'(1) - dy;
        end
        dx_d   = x2_q - x1_q;
        xmaj_d = (dx_d >= dy1_d);
        qd_d   = xmaj_d ? dx_d + CRD_W'(1) : dy1_d + CRD_W'(1);
        if ((dy > 0) ? (y2_q < 0 || y1_q >= syl) : (y1_q < 0 || y2_q >= syl)) begin
          state_d = F_KILL;
        end else begin
          job_d   = J_XS;
          state_d = F_MUL;
        end
      end
      F_MUL: begin
        prod_d  = op_a * op_b;
        den_d   = op_d;
        state_d = F_DIVGO;
      end
      F_DIVGO: begin
        div_start = 1'b1;
        state_d   = F_DIVW;
      end
      F_DIVW: begin
        if (div_done) state_d = F_APPLY;
      end
      F_APPLY: begin
        state_d = F_MUL;
        unique case (job_q)
          J_XL_Y: begin y1_d = y1_q + qc; job_d = J_XL_C; k_d = '0; end
          J_XR_Y: begin y2_d = y2_q - qc; job_d = J_XR_C; k_d = '0; end
          J_YT_X: begin x1_d = x1_q + qc; job_d = J_YT_C; k_d = '0; end
          J_YB_X: begin x2_d = x2_q - qc; job_d = J_YB_C; k_d = '0; end
          J_XS:   begin xstep_d = quot[ACC_W-1:0]; job_d = J_CS; k_d = '0; end
          J_XL_C: c1_d[k_q] = c1_q[k_q] + q8;
          J_YT_C: c1_d[k_q] = c1_q[k_q] + q8;
          J_XR_C: c2_d[k_q] = c2_q[k_q] - q8;
          J_YB_C: c2_d[k_q] = c2_q[k_q] - q8;
          J_CS:   cstep_d[k_q] = quot[ACC_W-1:0];
          default: ;
        endcase
        if (job_q == J_XL_C || job_q == J_XR_C || job_q == J_YT_C ||
            job_q == J_YB_C || job_q == J_CS) begin
          k_d = k_q + 2'd1;
          if (k_q == 2'd2) begin
            k_d = '0;
            unique case (job_q)
              J_XL_C: begin x1_d = '0; state_d = F_XR; end
              J_XR_C: begin x2_d = sxl - CRD_W'(1); state_d = F_YT; end
              J_YT_C: begin y1_d = '0; state_d = F_YB; end
              J_YB_C: begin y2_d = syl - CRD_W'(1); state_d = F_FIN; end
              default: state_d = F_SEND;
            endcase
          end
        end
      end
      F_SEND: begin
        cmd_valid_o = 1'b1;
        if (cmd_ready_i) state_d = F_IDLE;
      end
      F_KILL: begin
        cmd_valid_o = 1'b1;
        if (cmd_ready_i) state_d = F_IDLE;
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      job_q   <= J_XL_Y;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      job_q   <= job_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x1_q    <= x1_d;
    y1_q    <= y1_d;
    x2_q    <= x2_d;
    y2_q    <= y2_d;
    c1_q    <= c1_d;
    c2_q    <= c2_d;
    lw_q    <= lw_d;
    xne_q   <= xne_d;
    yne_q   <= yne_d;
    dir_q   <= dir_d;
    xmaj_q  <= xmaj_d;
    dy1_q   <= dy1_d;
    dx_q    <= dx_d;
    qd_q    <= qd_d;
    xstep_q <= xstep_d;
    cstep_q <= cstep_d;
    prod_q  <= prod_d;
    den_q   <= den_d;
  end

`ifndef SYNTHESIS
  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == F_DIVGO |=> state_q == F_DIVW)
    else $error("divider not waited on");
  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_pop |-> state_q == F_IDLE && in_cnt_q != 2'd0)
    else $error("input popped while busy");
  a_in_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_cnt_q != 2'd3)
    else $error("input queue overflow");
`endif

endmodule

`default_nettype wire

// File: rtl/core/swlr_walk.sv
`timescale 1ns / 1ps
`default_nettype none

module swlr_walk import swlr_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire cfg_t cfg_i,
  input  wire logic cmd_valid_i,
  input  wire cmd_t cmd_i,
  output logic      cmd_ready_o,
  output logic      empty_o,
  input  wire logic pop_i,
  output res_t      res_o
);

  // command queue
  cmd_t       mid_mem_q [2];
  logic       mid_wr_q, mid_rd_q;
  logic [1:0] mid_cnt_q;
  logic       mid_push, mid_pop;
  cmd_t       cmd;

  assign cmd_ready_o = (mid_cnt_q != 2'd2);
  assign mid_push    = cmd_valid_i && cmd_ready_o;
  assign cmd         = mid_mem_q[mid_rd_q];

  always_ff @(posedge clk_i) begin
    if (mid_push) mid_mem_q[mid_wr_q] <= cmd_i;
  end

  // result queue
  res_t       out_mem_q [2];
  logic       out_wr_q, out_rd_q;
  logic [1:0] out_cnt_q;
  logic       out_push, out_pop, out_full;
  res_t       out_d;

  assign empty_o  = (out_cnt_q == 2'd0);
  assign out_full = (out_cnt_q == 2'd2);
  assign out_pop  = pop_i && !empty_o;
  assign res_o    = out_mem_q[out_rd_q];

  always_ff @(posedge clk_i) begin
    if (out_push) out_mem_q[out_wr_q] <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_wr_q  <= 1'b0;
      mid_rd_q  <= 1'b0;
      mid_cnt_q <= '0;
      out_wr_q  <= 1'b0;
      out_rd_q  <= 1'b0;
      out_cnt_q <= '0;
    end else begin
      if (mid_push) mid_wr_q <= !mid_wr_q;
      if (mid_pop) mid_rd_q <= !mid_rd_q;
      mid_cnt_q <= mid_cnt_q + {1'b0, mid_push} - {1'b0, mid_pop};
      if (out_push) out_wr_q <= !out_wr_q;
      if (out_pop) out_rd_q <= !out_rd_q;
      out_cnt_q <= out_cnt_q + {1'b0, out_push} - {1'b0, out_pop};
    end
  end

  walk_e                    state_q, state_d;
  logic                     active_q, active_d;
  logic                     xmaj_q, xmaj_d, dir_q, dir_d, pend_q, pend_d;
  logic [ACC_W-1:0]         acc_q, acc_d, step_q, step_d;
  logic [15:0]              row_q, row_d;
  logic [ROWS_W-1:0]        rows_q, rows_d;
  logic signed [COL_W-1:0]  col_q, col_d;
  logic signed [SPAN_W-1:0] span_q, span_d, lo_q, lo_d, hi_q, hi_d, span_n;
  logic [2:0][ACC_W-1:0]    cacc_q, cacc_d, cstep_q, cstep_d;
  res_t                     pix_q, pix_d, pix;
  logic [ACC_W-1:0]         accn;
  logic signed [COL_W-1:0]  ce, cur, col_n;
  logic                     do_next;

  assign accn   = acc_q + step_q;
  assign ce     = col_floor(accn);
  assign cur    = col_floor(acc_q);
  assign col_n  = col_q + COL_W'(1);
  assign span_n = span_q + SPAN_W'(1);

  always_comb begin
    pix.pixel_valid = 1'b1;
    pix.last_pixel  = 1'b0;
    if (xmaj_q) begin
      pix.pixel_x = col_q[15:0] - cfg_i.origin_x;
      pix.pixel_y = row_q - cfg_i.origin_y + 16'(span_q);
    end else begin
      pix.pixel_x = cur[15:0] - cfg_i.origin_x + 16'(span_q);
      pix.pixel_y = row_q - cfg_i.origin_y;
    end
    if (span_q == '0 && (hi_q - lo_q) > SPAN_W'(MARKER_MIN)) begin
      pix.pixel_color = MARKER_COLOR;
    end else begin
      for (int i = 0; i < 3; i++)
        pix.pixel_color[8*i +: 8] = cacc_q[i][FRAC_BITS +: 8];
    end
  end

  always_comb begin
    state_d  = state_q;
    active_d = active_q;
    xmaj_d   = xmaj_q;
    dir_d    = dir_q;
    pend_d   = pend_q;
    acc_d    = acc_q;
    step_d   = step_q;
    row_d    = row_q;
    rows_d   = rows_q;
    col_d    = col_q;
    span_d   = span_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    cacc_d   = cacc_q;
    cstep_d  = cstep_q;
    pix_d    = pix_q;
    mid_pop  = 1'b0;
    out_push = 1'b0;
    do_next  = 1'b0;
    out_d    = pix_q;
    out_d.last_pixel = pix_q.pixel_valid && !active_q;
    unique case (state_q)
      W_IDLE: begin
        if (mid_cnt_q != 2'd0) begin
          mid_pop = 1'b1;
          unique case (cmd.kind)
            CMD_KILL: active_d = 1'b0;
            CMD_SETUP: begin
              active_d = 1'b1;
              xmaj_d   = cmd.line.x_major;
              dir_d    = cmd.line.row_dir;
              acc_d    = cmd.line.x_acc;
              step_d   = cmd.line.x_step;
              row_d    = cmd.line.row_y;
              rows_d   = cmd.line.rows_left;
              col_d    = col_floor(cmd.line.x_acc);
              span_d   = cmd.line.span_lo;
              lo_d     = cmd.line.span_lo;
              hi_d     = cmd.line.span_hi;
              cacc_d   = cmd.line.c_acc;
              cstep_d  = cmd.line.c_step;
              pend_d   = 1'b0;
              state_d  = W_SKIP;
            end
            default: begin
              if (!active_q) begin
                pix_d   = '0;
                state_d = W_PUSH;
              end else begin
                pix_d   = pix;
                pend_d  = 1'b1;
                state_d = W_SKIP;
                if (span_n < hi_q) begin
                  span_d = span_n;
                end else begin
                  span_d = lo_q;
                  for (int i = 0; i < 3; i++) cacc_d[i] = cacc_q[i] + cstep_q[i];
                  if (xmaj_q && col_n <= ce) col_d = col_n;
                  else do_next = 1'b1;
                end
              end
            end
          endcase
        end
      end
      W_SKIP: begin
        if (active_q && xmaj_q && col_q > ce) do_next = 1'b1;
        else state_d = pend_q ? W_PUSH : W_IDLE;
      end
      W_PUSH: begin
        if (!out_full) begin
          out_push = 1'b1;
          state_d  = W_IDLE;
        end
      end
      default: state_d = W_IDLE;
    endcase
    if (do_next) begin
      acc_d  = accn;
      row_d  = dir_q ? row_q - 16'd1 : row_q + 16'd1;
      rows_d = rows_q - ROWS_W'(1);
      if (rows_q == ROWS_W'(1)) active_d = 1'b0;
      else if (xmaj_q) col_d = ce;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= W_IDLE;
      active_q <= 1'b0;
      pend_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      active_q <= active_d;
      pend_q   <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    xmaj_q  <= xmaj_d;
    dir_q   <= dir_d;
    acc_q   <= acc_d;
    step_q  <= step_d;
    row_q   <= row_d;
    rows_q  <= rows_d;
    col_q   <= col_d;
    span_q  <= span_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    cacc_q  <= cacc_d;
    cstep_q <= cstep_d;
    pix_q   <= pix_d;
  end

`ifndef SYNTHESIS
  a_push_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == W_PUSH && !out_full |=> state_q == W_IDLE)
    else $error("result transfer did not return to idle");
  a_kill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == W_IDLE && mid_pop && cmd.kind == CMD_KILL |=> !active_q)
    else $error("line still active after kill");
  a_out_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push |-> out_cnt_q != 2'd2 || out_pop)
    else $error("result queue overflow");
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_cnt_q != 2'd3 && out_cnt_q != 2'd3)
    else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

// File: rtl/core/shaded_wide_line_rasterizer.sv
// channel | handshake             | payload
// input   | push / full           | opcode_i, start/end x y, colors, line_width_i
// result  | empty / pop           | pixel_valid_o, pixel_x/y_o, pixel_color_o, last_pixel_o
// config  | cfg_valid / cfg_ready | cfg_index_i, cfg_data_i
//
// an advance item passes from the input queue through the command queue and the walker into the result queue
// a start item that is drawn runs 4 to 20 divisions on the shared 36-step divider
// a line dropped at the first x test needs no division; one dropped at the final y test may have run clip divisions
// reset clears all queues and leaves no line active; config resets to 640 x 480, origin 0
// a full result queue stalls the walker; the setup side keeps working into its command queue
`timescale 1ns / 1ps
`default_nettype none

module shaded_wide_line_rasterizer import swlr_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic        opcode_i,
  input  wire logic [15:0] start_x_i,
  input  wire logic [15:0] start_y_i,
  input  wire logic [15:0] end_x_i,
  input  wire logic [15:0] end_y_i,
  input  wire logic [23:0] start_color_i,
  input  wire logic [23:0] end_color_i,
  input  wire logic [5:0]  line_width_i,
  output logic             empty,
  input  wire logic        pop,
  output logic             pixel_valid_o,
  output logic [15:0]      pixel_x_o,
  output logic [15:0]      pixel_y_o,
  output logic [23:0]      pixel_color_o,
  output logic             last_pixel_o,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  cfg_t     cfg_q;
  in_item_t item;
  logic     cmd_valid, cmd_ready;
  cmd_t     cmd;
  res_t     res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.clip_width  <= 13'd640;
      cfg_q.clip_height <= 13'd480;
      cfg_q.origin_x    <= '0;
      cfg_q.origin_y    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_e'(cfg_index_i))
        REG_CLIP_W: cfg_q.clip_width  <= cfg_data_i[12:0];
        REG_CLIP_H: cfg_q.clip_height <= cfg_data_i[12:0];
        REG_ORG_X:  cfg_q.origin_x    <= cfg_data_i;
        REG_ORG_Y:  cfg_q.origin_y    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign item.opcode      = opcode_i;
  assign item.start_x     = start_x_i;
  assign item.start_y     = start_y_i;
  assign item.end_x       = end_x_i;
  assign item.end_y       = end_y_i;
  assign item.start_color = start_color_i;
  assign item.end_color   = end_color_i;
  assign item.line_width  = line_width_i;

  swlr_setup u_setup (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .push_i     (push),
    .item_i     (item),
    .full_o     (full),
    .cmd_valid_o(cmd_valid),
    .cmd_o      (cmd),
    .cmd_ready_i(cmd_ready)
  );

  swlr_walk u_walk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd),
    .cmd_ready_o(cmd_ready),
    .empty_o    (empty),
    .pop_i      (pop),
    .res_o      (res)
  );

  assign pixel_valid_o = res.pixel_valid;
  assign pixel_x_o     = res.pixel_x;
  assign pixel_y_o     = res.pixel_y;
  assign pixel_color_o = res.pixel_color;
  assign last_pixel_o  = res.last_pixel;

endmodule

`default_nettype wire
